>>> sv/lzwe_pkg.sv
// ----------------------------------------------------------------------------
// LZW byte encoder package
// Shared sizes and the types that pass between the encoder's modules.
// ----------------------------------------------------------------------------
package lzwe_pkg;

   localparam int CODE_WIDTH     = 12;
   localparam int SYM_WIDTH      = 8;
   localparam int FREE_WIDTH     = CODE_WIDTH + 1;
   localparam int FIRST_FREE     = 256;
   localparam int CODE_LIMIT     = 1 << CODE_WIDTH;
   localparam int DICT_DEPTH     = CODE_LIMIT - FIRST_FREE;
   localparam int DICT_ADDR_BITS = $clog2(DICT_DEPTH);
   localparam int HASH_BITS      = CODE_WIDTH + 1;
   localparam int HASH_DEPTH     = 1 << HASH_BITS;
   localparam int RSP_DEPTH      = 2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_ENTRY,
      ST_EMIT_PFX,
      ST_EMIT_LAST
   } lzwe_state_type;

   typedef struct packed {
      logic [CODE_WIDTH-1:0] prefix;
      logic [SYM_WIDTH-1:0]  sym;
      logic [HASH_BITS-1:0]  slot;
   } entry_type;

   typedef struct packed {
      logic                      hash_rd_en;
      logic [HASH_BITS-1:0]      hash_rd_addr;
      logic                      hash_wr_en;
      logic [HASH_BITS-1:0]      hash_wr_addr;
      logic [CODE_WIDTH-1:0]     hash_wr_data;
      logic                      ent_rd_en;
      logic [DICT_ADDR_BITS-1:0] ent_rd_addr;
      logic                      ent_wr_en;
      logic [DICT_ADDR_BITS-1:0] ent_wr_addr;
      entry_type                 ent_wr_data;
   } dict_req_type;

   typedef struct packed {
      logic [CODE_WIDTH-1:0] hash_data;
      entry_type             ent_data;
   } dict_rsp_type;

   typedef struct packed {
      logic [CODE_WIDTH-1:0] code;
      logic                  last;
   } rsp_beat_type;

endpackage

>>> sv/lzwe_dict.sv
// ----------------------------------------------------------------------------
// LZW dictionary memories
// Hash table of codes and the entry table (prefix, byte, owning slot) by code.
// ----------------------------------------------------------------------------
module lzwe_dict import lzwe_pkg::*; (
   input  logic         clock,
   input  dict_req_type dict_req,
   output dict_rsp_type dict_rsp
);

   logic [CODE_WIDTH-1:0] hash_mem [0:HASH_DEPTH-1];
   entry_type             ent_mem  [0:DICT_DEPTH-1];

   logic [CODE_WIDTH-1:0] hash_data_ff;
   entry_type             ent_data_ff;

   always_ff @(posedge clock) begin
      if (dict_req.hash_wr_en) begin
         hash_mem[dict_req.hash_wr_addr] <= dict_req.hash_wr_data;
      end
      if (dict_req.hash_rd_en) begin
         hash_data_ff <= hash_mem[dict_req.hash_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dict_req.ent_wr_en) begin
         ent_mem[dict_req.ent_wr_addr] <= dict_req.ent_wr_data;
      end
      if (dict_req.ent_rd_en) begin
         ent_data_ff <= ent_mem[dict_req.ent_rd_addr];
      end
   end

   assign dict_rsp.hash_data = hash_data_ff;
   assign dict_rsp.ent_data  = ent_data_ff;

endmodule

>>> sv/lzwe_rsp_fifo.sv
// ----------------------------------------------------------------------------
// LZW result queue
// Small queue that holds emitted codes until the result side takes them.
// ----------------------------------------------------------------------------
module lzwe_rsp_fifo import lzwe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_beat_type push_beat,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_beat
);

   localparam int PTR_BITS = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(RSP_DEPTH + 1);

   rsp_beat_type          mem [0:RSP_DEPTH-1];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  pop;

   function automatic logic [PTR_BITS-1:0] ptr_step(input logic [PTR_BITS-1:0] p);
      if (p == PTR_BITS'(RSP_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign rsp_valid = (count_ff != '0);
   assign full      = (count_ff == CNT_BITS'(RSP_DEPTH));
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_beat  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

>>> sv/lzwe_ctrl.sv
// ----------------------------------------------------------------------------
// LZW encoder sequencer
// Probes the hash table, verifies entries, inserts new codes and emits codes.
// ----------------------------------------------------------------------------
module lzwe_ctrl import lzwe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SYM_WIDTH-1:0] req_symbol,
   input  logic                 req_last_symbol,
   output dict_req_type         dict_req,
   input  dict_rsp_type         dict_rsp,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output rsp_beat_type         rsp_push_beat
);

   lzwe_state_type        st_ff, st_in;
   logic [SYM_WIDTH-1:0]  sym_ff, sym_in;
   logic                  last_ff, last_in;
   logic [CODE_WIDTH-1:0] prefix_ff, prefix_in;
   logic                  held_ff, held_in;
   logic [FREE_WIDTH-1:0] next_free_ff, next_free_in;
   logic [HASH_BITS-1:0]  slot_ff, slot_in;
   logic [CODE_WIDTH-1:0] cand_ff, cand_in;
   logic [HASH_BITS-1:0]  clr_addr_ff, clr_addr_in;

   logic                  accept;
   logic [HASH_BITS-1:0]  req_slot;
   logic [HASH_BITS-1:0]  next_slot;
   logic                  cand_live;
   logic                  slot_owned;
   logic                  key_match;
   logic                  dict_room;
   logic                  clr_done;
   logic                  ent_probe;
   logic                  ent_hit;
   logic                  miss;
   logic                  insert;

   function automatic logic [HASH_BITS-1:0] slot_hash(
      input logic [CODE_WIDTH-1:0] p,
      input logic [SYM_WIDTH-1:0]  s
   );
      return {s, {(HASH_BITS - SYM_WIDTH){1'b0}}} ^ HASH_BITS'(p);
   endfunction

   function automatic logic [DICT_ADDR_BITS-1:0] dict_addr(input logic [CODE_WIDTH-1:0] c);
      logic [CODE_WIDTH-1:0] off;
      off = c - CODE_WIDTH'(FIRST_FREE);
      return off[DICT_ADDR_BITS-1:0];
   endfunction

   // A slot is live only if its code belongs to this message and the entry of
   // that code points back at the slot; anything else counts as an empty slot.
   always_comb begin
      accept     = (st_ff == ST_IDLE) && req_valid;
      req_slot   = slot_hash(prefix_ff, req_symbol);
      next_slot  = slot_ff + 1'b1;
      cand_live  = (dict_rsp.hash_data >= CODE_WIDTH'(FIRST_FREE)) &&
                   (FREE_WIDTH'(dict_rsp.hash_data) < next_free_ff);
      slot_owned = (dict_rsp.ent_data.slot == slot_ff);
      key_match  = (dict_rsp.ent_data.prefix == prefix_ff) &&
                   (dict_rsp.ent_data.sym == sym_ff);
      dict_room  = (next_free_ff < FREE_WIDTH'(CODE_LIMIT));
      clr_done   = (clr_addr_ff == '1);
      ent_hit    = (st_ff == ST_ENTRY) && slot_owned && key_match;
      ent_probe  = (st_ff == ST_ENTRY) && slot_owned && !key_match;
      miss       = ((st_ff == ST_HASH) && !cand_live) ||
                   ((st_ff == ST_ENTRY) && !slot_owned);
      insert     = miss && dict_room;
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_CLEAR: begin
            if (clr_done) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (held_ff) begin
                  st_in = ST_HASH;
               end else if (req_last_symbol) begin
                  st_in = ST_EMIT_LAST;
               end
            end
         end
         ST_HASH: begin
            st_in = cand_live ? ST_ENTRY : ST_EMIT_PFX;
         end
         ST_ENTRY: begin
            if (ent_hit) begin
               st_in = last_ff ? ST_EMIT_LAST : ST_IDLE;
            end else if (ent_probe) begin
               st_in = ST_HASH;
            end else begin
               st_in = ST_EMIT_PFX;
            end
         end
         ST_EMIT_PFX: begin
            if (!rsp_full) begin
               st_in = last_ff ? ST_EMIT_LAST : ST_IDLE;
            end
         end
         ST_EMIT_LAST: begin
            if (!rsp_full) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_stall = (st_ff != ST_IDLE);

      dict_req.hash_rd_en   = (accept && held_ff) || ent_probe;
      dict_req.hash_rd_addr = (st_ff == ST_ENTRY) ? next_slot : req_slot;
      dict_req.hash_wr_en   = (st_ff == ST_CLEAR) || insert;
      dict_req.hash_wr_addr = (st_ff == ST_CLEAR) ? clr_addr_ff : slot_ff;
      dict_req.hash_wr_data = (st_ff == ST_CLEAR) ? '0 : next_free_ff[CODE_WIDTH-1:0];
      dict_req.ent_rd_en    = (st_ff == ST_HASH) && cand_live;
      dict_req.ent_rd_addr  = dict_addr(dict_rsp.hash_data);
      dict_req.ent_wr_en    = insert;
      dict_req.ent_wr_addr  = dict_addr(next_free_ff[CODE_WIDTH-1:0]);
      dict_req.ent_wr_data.prefix = prefix_ff;
      dict_req.ent_wr_data.sym    = sym_ff;
      dict_req.ent_wr_data.slot   = slot_ff;

      rsp_push           = ((st_ff == ST_EMIT_PFX) || (st_ff == ST_EMIT_LAST)) && !rsp_full;
      rsp_push_beat.code = prefix_ff;
      rsp_push_beat.last = (st_ff == ST_EMIT_LAST);
   end

   always_comb begin
      sym_in       = sym_ff;
      last_in      = last_ff;
      prefix_in    = prefix_ff;
      held_in      = held_ff;
      next_free_in = next_free_ff;
      slot_in      = slot_ff;
      cand_in      = cand_ff;
      clr_addr_in  = clr_addr_ff;

      if (st_ff == ST_CLEAR) begin
         clr_addr_in = clr_addr_ff + 1'b1;
      end
      if (accept) begin
         sym_in  = req_symbol;
         last_in = req_last_symbol;
         if (held_ff) begin
            slot_in = req_slot;
         end else begin
            prefix_in = CODE_WIDTH'(req_symbol);
            held_in   = 1'b1;
         end
      end
      if ((st_ff == ST_HASH) && cand_live) begin
         cand_in = dict_rsp.hash_data;
      end
      if (ent_hit) begin
         prefix_in = cand_ff;
      end
      if (ent_probe) begin
         slot_in = next_slot;
      end
      if (insert) begin
         next_free_in = next_free_ff + 1'b1;
      end
      if ((st_ff == ST_EMIT_PFX) && !rsp_full) begin
         prefix_in = CODE_WIDTH'(sym_ff);
      end
      if ((st_ff == ST_EMIT_LAST) && !rsp_full) begin
         held_in      = 1'b0;
         prefix_in    = '0;
         next_free_in = FREE_WIDTH'(FIRST_FREE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         clr_addr_ff  <= '0;
         held_ff      <= 1'b0;
         prefix_ff    <= '0;
         next_free_ff <= FREE_WIDTH'(FIRST_FREE);
      end else begin
         st_ff        <= st_in;
         clr_addr_ff  <= clr_addr_in;
         held_ff      <= held_in;
         prefix_ff    <= prefix_in;
         next_free_ff <= next_free_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      last_ff <= last_in;
      slot_ff <= slot_in;
      cand_ff <= cand_in;
   end

endmodule

>>> sv/lzw_byte_encoder_top.sv
// ----------------------------------------------------------------------------
// LZW byte encoder, top level
// Encodes a byte stream into LZW codes using a hashed dictionary in memory.
// ----------------------------------------------------------------------------
// Input: the byte that opens a message only starts the prefix. Any other
// byte holds req_stall high while its lookup reads the hash table, then the
// entry table if the slot holds a live code, again for each extra probe.
// A final byte adds the last emit; a full result queue holds an emit back.
// Output: a miss code enters the result queue from ST_EMIT_PFX, a final code
// from ST_EMIT_LAST. Reset: a clearing pass writes all 8192 hash slots, one
// a cycle, with req_stall held high; then the dictionary is empty.
// ----------------------------------------------------------------------------
module lzw_byte_encoder_top import lzwe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SYM_WIDTH-1:0]  req_symbol,
   input  logic                  req_last_symbol,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CODE_WIDTH-1:0] rsp_code,
   output logic                  rsp_last_code
);

   // The dictionary is split in two memories. The hash table maps a slot to a
   // code; the entry table, addressed by code, holds the (prefix, byte) pair
   // and the slot that owns the code. A slot counts as occupied only when its
   // code is below the next free code and the entry points back at the slot,
   // so starting a new message needs no clearing: resetting the next free
   // code retires every slot at once.
   dict_req_type dict_req;
   dict_rsp_type dict_rsp;
   logic         rsp_full;
   logic         rsp_push;
   rsp_beat_type rsp_push_beat;
   rsp_beat_type rsp_beat;

   // The sequencer handles one byte at a time. Each probe reads the hash table
   // and then the entry table. Writes happen only in cycles that issue no
   // read, so no access to one entry ever overlaps another.
   lzwe_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_symbol      (req_symbol),
      .req_last_symbol (req_last_symbol),
      .dict_req        (dict_req),
      .dict_rsp        (dict_rsp),
      .rsp_full        (rsp_full),
      .rsp_push        (rsp_push),
      .rsp_push_beat   (rsp_push_beat)
   );

   lzwe_dict u_dict (
      .clock    (clock),
      .dict_req (dict_req),
      .dict_rsp (dict_rsp)
   );

   // Codes wait in a two-beat queue, so the next byte beat is taken while the
   // result side stalls.
   lzwe_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_beat (rsp_push_beat),
      .full      (rsp_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   assign rsp_code      = rsp_beat.code;
   assign rsp_last_code = rsp_beat.last;

   // The clearing pass holds off input beats right after reset.
   a_stall_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("input beat possible during the clearing pass");

   // The hash table is never read and written in the same cycle.
   a_hash_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(dict_req.hash_wr_en && dict_req.hash_rd_en))
      else $error("hash table read and write overlap");

   // The entry table is never read and written in the same cycle.
   a_ent_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(dict_req.ent_wr_en && dict_req.ent_rd_en))
      else $error("entry table read and write overlap");

   // A code is never pushed into a full result queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(rsp_push && rsp_full))
      else $error("result queue overflow");

endmodule

>>> tb/lzw_byte_encoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW byte encoder testbench
// Feeds byte messages to the encoder and checks each emitted code, in order,
// against a predictor that runs LZW on its own copy of the dictionary.
// ----------------------------------------------------------------------------
module lzw_byte_encoder_top_test import lzwe_pkg::*;;

   // One input beat as the sender queues it.
   typedef struct packed {
      logic [SYM_WIDTH-1:0] symbol;
      logic                 last_symbol;
   } byte_beat_type;

   // Clock, reset and the ports of the block. Every input starts at a known
   // value so nothing floats while reset is still being applied.
   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [SYM_WIDTH-1:0]  req_symbol      = '0;
   logic                  req_last_symbol = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [CODE_WIDTH-1:0] rsp_code;
   logic                  rsp_last_code;

   // Bytes waiting to be sent and codes the encoder still owes us.
   byte_beat_type pending_bytes [$];
   rsp_beat_type  expected_codes [$];

   // Predictor state: the dictionary maps a (prefix code, byte) pair to the
   // code it was given. Pairs are unique, so a map is as good as a search.
   logic [CODE_WIDTH-1:0] dict_code [logic [CODE_WIDTH+SYM_WIDTH-1:0]];
   logic [FREE_WIDTH-1:0] next_code    = FREE_WIDTH'(FIRST_FREE);
   logic [CODE_WIDTH-1:0] cur_prefix   = '0;
   logic                  prefix_held  = 1'b0;

   // Percent of cycles in which each side holds off.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned mismatch_count = 0;
   rsp_beat_type want_code;

   lzw_byte_encoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_symbol      (req_symbol),
      .req_last_symbol (req_last_symbol),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code        (rsp_code),
      .rsp_last_code   (rsp_last_code)
   );

   // 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // Runs one accepted byte through the LZW predictor and queues the codes
   // it must produce: the old prefix on a dictionary miss, and the remaining
   // prefix when the byte closes the message.
   task automatic encode_byte(input logic [SYM_WIDTH-1:0] sym, input logic is_last);
      logic [CODE_WIDTH+SYM_WIDTH-1:0] pair_key;
      rsp_beat_type                    beat;
      pair_key = {cur_prefix, sym};
      if (!prefix_held) begin
         // The first byte of a message only starts the prefix.
         cur_prefix  = CODE_WIDTH'(sym);
         prefix_held = 1'b1;
      end else if (dict_code.exists(pair_key)) begin
         cur_prefix = dict_code[pair_key];
      end else begin
         beat.code = cur_prefix;
         beat.last = 1'b0;
         expected_codes.push_back(beat);
         // Once the code space is used up the dictionary stays frozen.
         if (next_code < FREE_WIDTH'(CODE_LIMIT)) begin
            dict_code[pair_key] = next_code[CODE_WIDTH-1:0];
            next_code++;
         end
         cur_prefix = CODE_WIDTH'(sym);
      end
      if (is_last) begin
         beat.code = cur_prefix;
         beat.last = 1'b1;
         expected_codes.push_back(beat);
         // Each message is coded on its own: start over with an empty table.
         prefix_held = 1'b0;
         cur_prefix  = '0;
         next_code   = FREE_WIDTH'(FIRST_FREE);
         dict_code.delete();
      end
   endtask

   // Sender. A new beat may be presented whenever the slot is empty or the
   // current beat is taken at this edge; a held beat never changes. Each
   // beat is predicted at the edge where the encoder takes it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            encode_byte(req_symbol, req_last_symbol);
         end
         if (pending_bytes.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            req_valid       <= 1'b1;
            req_symbol      <= pending_bytes[0].symbol;
            req_last_symbol <= pending_bytes[0].last_symbol;
            void'(pending_bytes.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. Every code beat taken is compared with the oldest expected
   // code; stall is redrawn every cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_codes.size() == 0) begin
               report_mismatch($sformatf("unexpected code %0d last %0b",
                                         rsp_code, rsp_last_code));
            end else begin
               want_code = expected_codes.pop_front();
               if (rsp_code !== want_code.code)
                  report_mismatch($sformatf("code %0d, expected %0d",
                                            rsp_code, want_code.code));
               if (rsp_last_code !== want_code.last)
                  report_mismatch($sformatf("last_code %0b, expected %0b (code %0d)",
                                            rsp_last_code, want_code.last, want_code.code));
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   task automatic push_byte(input logic [SYM_WIDTH-1:0] sym, input logic is_last);
      byte_beat_type beat;
      beat.symbol      = sym;
      beat.last_symbol = is_last;
      pending_bytes.push_back(beat);
   endtask

   // Queues len bytes drawn from a random alphabet of alpha_size symbols, or
   // from all 256 when alpha_size is zero. Small alphabets give long
   // dictionary hits; the full range mostly misses.
   task automatic add_message(input int len, input int alpha_size, input logic close_msg);
      logic [SYM_WIDTH-1:0] alphabet [0:3];
      logic [SYM_WIDTH-1:0] sym;
      for (int i = 0; i < 4; i++) alphabet[i] = SYM_WIDTH'($urandom);
      for (int i = 0; i < len; i++) begin
         if (alpha_size == 0) sym = SYM_WIDTH'($urandom);
         else sym = alphabet[$urandom_range(alpha_size - 1)];
         push_byte(sym, close_msg && (i == len - 1));
      end
   endtask

   // Mostly short messages, some single bytes, a few longer ones.
   task automatic add_random_traffic(input int n_items);
      int total;
      int len;
      int kind;
      total = 0;
      while (total < n_items) begin
         kind = $urandom_range(9);
         if (kind == 0) len = 1;
         else if (kind < 7) len = $urandom_range(40, 2);
         else len = $urandom_range(160, 40);
         add_message(len, ($urandom_range(3) == 0) ? 0 : $urandom_range(4, 1), 1'b1);
         total += len;
      end
   endtask

   // Holds the sender until every queued byte is taken and every code it
   // caused has come back. Sampled at the falling edge, when all the
   // clocked updates of the cycle have settled.
   task automatic wait_drained;
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_codes.size() != 0);
   endtask

   initial begin
      // Phase one: a lazy receiver, a busy sender.
      req_idle_pct = 18;
      rsp_idle_pct = 88;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed messages. A lone byte that is also the final one, at both
      // ends of the byte range.
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      // Alternating pair: builds two-byte and three-byte entries and ends the
      // message on a dictionary hit.
      for (int i = 0; i < 7; i++) push_byte((i % 2) ? 8'h42 : 8'h41, i == 6);
      // A run of one byte grows ever longer entries.
      for (int i = 0; i < 6; i++) push_byte(8'hFF, i == 5);
      // The final byte misses, so the message ends with two codes in a row.
      push_byte(8'h00, 1'b0);
      push_byte(8'h80, 1'b1);

      add_random_traffic(450);
      // One long message that builds a large dictionary with longer probe
      // chains, then keeps going with a small alphabet so long hits follow.
      add_message(300, 0, 1'b0);
      add_message(100, 3, 1'b1);
      // The sender waits here until nothing is owed.
      wait_drained();

      // Phase two: a sparse sender, an eager receiver.
      req_idle_pct = 88;
      rsp_idle_pct = 18;
      add_random_traffic(500);
      wait_drained();

      // Phase three: back to back on both sides.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      add_random_traffic(500);
      wait_drained();

      // Give any stray code time to show up.
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_codes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, including the clearing pass
   // after reset.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
